@@ design/wls_pkg.sv @@
// Shared types and codes for the wavetable LFO sequencer.
// No dependencies; imported by wavetable_lfo_sequencer_core.
package wls_pkg;

    // Fixed field widths
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int VAL_W       = 7;
    localparam int PHASE_W     = 8;
    localparam int STEP_W      = 6;
    localparam int DEST_W      = 5;
    localparam int ROUTE_W     = 19;
    localparam int NUM_FX      = 4;
    localparam logic [VAL_W-1:0] VAL_MAX = 7'd127;
    localparam logic [3:0] LAST_TICK_PHASE = 4'd11;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_LFO_MODE     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED        = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_MODE  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_LENGTH  = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_MASK = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE       = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROUTE_BASE   = 4'd6;

    // LFO modes
    localparam logic [1:0] MODE_FREE    = 2'd0;
    localparam logic [1:0] MODE_ONESHOT = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_OFFSET = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] clock_phase;
        logic       slot_select;
        logic [5:0] table_index;
        logic [6:0] table_value;
        logic [4:0] dest_select;
        logic [6:0] offset_value;
    } cmd_word_t;

    typedef struct packed {
        logic       target_is_fx;
        logic [3:0] target_index;
        logic [6:0] param_number;
        logic [6:0] mod_value;
        logic       last;
    } res_word_t;

endpackage

@@ design/wavetable_lfo_sequencer_core.sv @@
// Wavetable LFO sequencer: top level with sequencer, wave memory and output register.
// Depends on wls_pkg for word types, command codes and register indexes.
//
// Usage:
//   cmd/cmd_valid/cmd_ready carries command words: clock tick, wave sample load,
//   base offset load. res/res_valid/res_ready carries one word per routed slot
//   on an enabled tick, slots in order, with last set on the tick's final word.
//   Configuration is written through cfg_wr_en/cfg_index/cfg_data; the user must
//   write it only while idle, as the block does not enforce this. Load and offset
//   commands finish on acceptance. On a tick each routed slot passes the wave
//   memory read, then the shared value adder/clamp; other slots skip the value
//   stage; an update state then sets phase and step. The first result is registered
//   after the scan and value states. cmd_ready is low while a tick is in progress.
//   A stalled receiver holds the result register; the sequencer waits in the
//   value stage until the word is taken, so nothing is lost or repeated.
//   Reset clears phase, divider, step counter, offsets and configuration;
//   wave memory contents are undefined until loaded. No clearing pass.
module wavetable_lfo_sequencer_core
    import wls_pkg::*;
#(
    parameter int WAVE_LENGTH = 48,
    parameter int NUM_SLOTS   = 2,
    parameter int NUM_TRACKS  = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  cmd_word_t              cmd,
    input  logic                   cmd_valid,
    output logic                   cmd_ready,
    output res_word_t              res,
    output logic                   res_valid,
    input  logic                   res_ready
);

    localparam int SPAN      = WAVE_LENGTH + 1;
    localparam int MEM_DEPTH = NUM_SLOTS * SPAN;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [ADDR_W-1:0]  SPAN_A    = ADDR_W'(SPAN);
    localparam logic [PHASE_W-1:0] PHASE_END = PHASE_W'(WAVE_LENGTH);
    localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [DEST_W-1:0]  DEST_TRK  = DEST_W'(NUM_TRACKS);
    localparam logic [DEST_W-1:0]  DEST_MAX  = DEST_W'(NUM_TRACKS + NUM_FX);

    // Configuration
    logic [1:0]         lfo_mode_reg;
    logic [6:0]         speed_reg;
    logic               offset_mode_reg;
    logic [6:0]         step_length_reg;
    logic [63:0]        trigger_mask_reg;
    logic               enable_reg;
    logic [ROUTE_W-1:0] route_reg [NUM_SLOTS];

    // LFO state
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [6:0]         hold_reg, hold_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [VAL_W-1:0]   offset_reg [NUM_SLOTS];

    // Sequencer
    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               adv_step_reg;
    logic               res_valid_reg, res_valid_next;
    res_word_t          res_reg, res_next;

    // Wave memory
    logic [VAL_W-1:0]   wave_mem [MEM_DEPTH];
    logic [VAL_W-1:0]   rd_data_reg;
    logic               rd_ok_reg;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic               wr_en;

    logic               accept;
    logic               slot_active [NUM_SLOTS];
    logic               later_active;
    logic               retrigger;

    // Value unit
    logic [DEST_W-1:0]  cur_dest;
    logic [VAL_W-1:0]   cur_depth, sub_amt, wave_val;
    logic signed [9:0]  sum;
    logic [VAL_W-1:0]   clamped;

    assign accept    = cmd_valid && cmd_ready;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    always_comb
    begin
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            slot_active[s] = (route_reg[s][18:14] != '0) &&
                             (route_reg[s][18:14] <= DEST_MAX);
        end
        later_active = 1'b0;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            if ((SLOT_W'(s) > slot_reg) && slot_active[s])
                later_active = 1'b1;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfo_mode_reg     <= '0;
            speed_reg        <= '0;
            offset_mode_reg  <= 1'b0;
            step_length_reg  <= 7'd16;
            trigger_mask_reg <= '0;
            enable_reg       <= 1'b0;
            for (int s = 0; s < NUM_SLOTS; s++)
                route_reg[s] <= '0;
        end
        else if (cfg_wr_en)
        begin
            priority case (cfg_index)
                CFG_LFO_MODE:     lfo_mode_reg     <= cfg_data[1:0];
                CFG_SPEED:        speed_reg        <= cfg_data[6:0];
                CFG_OFFSET_MODE:  offset_mode_reg  <= cfg_data[0];
                CFG_STEP_LENGTH:  step_length_reg  <= cfg_data[6:0];
                CFG_TRIGGER_MASK: trigger_mask_reg <= cfg_data;
                CFG_ENABLE:       enable_reg       <= cfg_data[0];
                default:
                begin
                    for (int s = 0; s < NUM_SLOTS; s++)
                    begin
                        if (cfg_index == CFG_INDEX_W'(int'(CFG_ROUTE_BASE) + s))
                            route_reg[s] <= cfg_data[ROUTE_W-1:0];
                    end
                end
            endcase
        end
    end

    // Base offsets follow the destination of each route
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SLOTS; s++)
                offset_reg[s] <= '0;
        end
        else if (accept && cmd.command == CMD_OFFSET)
        begin
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                if (route_reg[s][18:14] == cmd.dest_select)
                    offset_reg[s] <= cmd.offset_value;
            end
        end
    end

    // Wave memory: one write port, one registered read port
    assign wr_en   = accept && (cmd.command == CMD_LOAD) &&
                     (int'(cmd.slot_select) < NUM_SLOTS) &&
                     (int'(cmd.table_index) <= WAVE_LENGTH);
    assign wr_addr = ADDR_W'(cmd.slot_select) * SPAN_A + ADDR_W'(cmd.table_index);
    assign rd_addr = ADDR_W'(slot_reg) * SPAN_A + ADDR_W'(phase_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            wave_mem[wr_addr] <= cmd.table_value;
        if (state_reg == ST_SCAN)
        begin
            rd_data_reg <= wave_mem[rd_addr];
            rd_ok_reg   <= (phase_reg <= PHASE_END);
        end
    end

    // Shared value unit: offset + wave - depth (or depth/2), clamp to 0..127
    always_comb
    begin
        cur_dest  = route_reg[slot_reg][18:14];
        cur_depth = route_reg[slot_reg][6:0];
        sub_amt   = offset_mode_reg ? cur_depth : (cur_depth >> 1);
        wave_val  = rd_ok_reg ? rd_data_reg : '0;
        sum       = $signed({3'b000, offset_reg[slot_reg]}) +
                    $signed({3'b000, wave_val}) -
                    $signed({3'b000, sub_amt});
        if (sum > $signed(10'(VAL_MAX)))
            clamped = VAL_MAX;
        else if (sum < 0)
            clamped = '0;
        else
            clamped = sum[VAL_W-1:0];
    end

    assign retrigger = (cmd.clock_phase == 4'd0) && (lfo_mode_reg != MODE_FREE) &&
                       trigger_mask_reg[step_reg];

    // Sequencer next state and phase/step update
    always_comb
    begin
        logic [PHASE_W-1:0] ph;
        logic [6:0]         hold_inc;
        logic [6:0]         len_m1;

        state_next     = state_reg;
        slot_next      = slot_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        phase_next     = phase_reg;
        hold_next      = hold_reg;
        step_next      = step_reg;
        ph             = phase_reg;
        hold_inc       = hold_reg + 7'd1;
        len_m1         = (step_length_reg == '0) ? 7'd0 : step_length_reg - 7'd1;

        // Drop the result word once taken
        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd.command == CMD_TICK)
                begin
                    if (retrigger)
                        phase_next = '0;
                    slot_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (enable_reg && slot_active[slot_reg])
                    state_next = ST_CALC;
                else if (slot_reg == SLOT_LAST)
                    state_next = ST_UPDATE;
                else
                    slot_next = slot_reg + SLOT_W'(1);
            end
            ST_CALC:
            begin
                // Hold until the output register is free
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next        = 1'b1;
                    res_next.target_is_fx = (cur_dest > DEST_TRK);
                    res_next.target_index = (cur_dest > DEST_TRK) ?
                                            4'(cur_dest - DEST_TRK - DEST_W'(1)) :
                                            4'(cur_dest - DEST_W'(1));
                    res_next.param_number = route_reg[slot_reg][13:7];
                    res_next.mod_value    = clamped;
                    res_next.last         = !later_active;
                    if (slot_reg == SLOT_LAST)
                        state_next = ST_UPDATE;
                    else
                    begin
                        slot_next  = slot_reg + SLOT_W'(1);
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_UPDATE:
            begin
                if (speed_reg == '0)
                    ph = phase_reg + PHASE_W'(2);
                else if (hold_inc >= speed_reg - 7'd1)
                begin
                    hold_next = '0;
                    ph        = phase_reg + PHASE_W'(1);
                end
                else
                    hold_next = hold_inc;
                if (ph > PHASE_END)
                    ph = (lfo_mode_reg == MODE_ONESHOT) ? PHASE_END : '0;
                phase_next = ph;
                if (adv_step_reg)
                begin
                    if ({1'b0, step_reg} >= len_m1)
                        step_next = '0;
                    else
                        step_next = step_reg + STEP_W'(1);
                end
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            res_valid_reg <= 1'b0;
            phase_reg     <= '0;
            hold_reg      <= '0;
            step_reg      <= '0;
            adv_step_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            res_valid_reg <= res_valid_next;
            phase_reg     <= phase_next;
            hold_reg      <= hold_next;
            step_reg      <= step_next;
            if (accept)
                adv_step_reg <= (cmd.clock_phase == LAST_TICK_PHASE);
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // Checks
    a_tick_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.command == CMD_TICK |=> state_reg == ST_SCAN)
        else $error("tick did not start slot scan");

    a_calc_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CALC |-> $past(state_reg) == ST_SCAN || $past(state_reg) == ST_CALC)
        else $error("value stage entered without memory read");

    a_update_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPDATE |=> state_reg == ST_IDLE && phase_reg <= PHASE_END)
        else $error("phase update left phase out of table");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_ready && state_reg == ST_CALC |=> $stable(res_reg))
        else $error("pending result overwritten");

endmodule

@@ bench/wavetable_lfo_sequencer_core_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for wavetable_lfo_sequencer_core: a directed table, then random phases.
// Result words are checked against typed rows or the in-bench sequencer model; needs wls_pkg.
module wavetable_lfo_sequencer_core_test;
    import wls_pkg::*;

    localparam int WAVE_LEN        = 48;
    localparam int SLOTS           = 2;
    localparam int TRACKS          = 16;
    localparam int SPAN            = WAVE_LEN + 1;
    localparam int LAST_DEST       = TRACKS + NUM_FX;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int STALL_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = 12;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 95;

    typedef struct {
        bit                     is_cfg;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
        cmd_word_t              w;
        int                     n_typed;
        res_word_t              t0;
        res_word_t              t1;
    } row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    cmd_word_t              cmd;
    logic                   cmd_valid;
    logic                   cmd_ready;
    res_word_t              res;
    logic                   res_valid;
    logic                   res_ready;

    int  cmd_tag;
    bit  steady;
    int  fails = 0;
    int  quiet_cycles = 0;

    // Sequencer model: configuration and state
    logic [1:0]         m_mode;
    logic [6:0]         m_speed;
    logic               m_peak;
    logic [6:0]         m_len;
    logic [63:0]        m_trig;
    logic               m_en;
    logic [ROUTE_W-1:0] m_route [SLOTS];
    int                 m_phase;
    int                 m_hold;
    int                 m_step;
    logic [6:0]         m_offs [SLOTS];
    logic [6:0]         m_wave [SLOTS*SPAN];

    res_word_t tick_words[$];
    res_word_t awaited_words[$];
    row_t      plan[$];

    wavetable_lfo_sequencer_core #(
        .WAVE_LENGTH(WAVE_LEN),
        .NUM_SLOTS  (SLOTS),
        .NUM_TRACKS (TRACKS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .res      (res),
        .res_valid(res_valid),
        .res_ready(res_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [CFG_DATA_W-1:0] route_code(int dest, int param, int depth);
        return 64'(dest * 16384 + param * 128 + depth);
    endfunction

    function automatic cmd_word_t make_word(logic [1:0] c, logic [3:0] ph, logic sl,
                                            logic [5:0] ti, logic [6:0] tv,
                                            logic [4:0] ds, logic [6:0] ov);
        cmd_word_t w;
        w.command      = c;
        w.clock_phase  = ph;
        w.slot_select  = sl;
        w.table_index  = ti;
        w.table_value  = tv;
        w.dest_select  = ds;
        w.offset_value = ov;
        return w;
    endfunction

    function automatic void add_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        row_t r;
        r.is_cfg  = 1'b1;
        r.idx     = idx;
        r.data    = data;
        r.w       = '0;
        r.n_typed = -1;
        r.t0      = '0;
        r.t1      = '0;
        plan.push_back(r);
    endfunction

    function automatic void add_cmd(cmd_word_t w, int n_typed = -1,
                                    res_word_t t0 = '0, res_word_t t1 = '0);
        row_t r;
        r.is_cfg  = 1'b0;
        r.idx     = '0;
        r.data    = '0;
        r.w       = w;
        r.n_typed = n_typed;
        r.t0      = t0;
        r.t1      = t1;
        plan.push_back(r);
    endfunction

    function automatic void model_reset();
        m_mode  = MODE_FREE;
        m_speed = '0;
        m_peak  = 1'b0;
        m_len   = 7'd16;
        m_trig  = '0;
        m_en    = 1'b0;
        m_phase = 0;
        m_hold  = 0;
        m_step  = 0;
        for (int s = 0; s < SLOTS; s++)
        begin
            m_route[s] = '0;
            m_offs[s]  = '0;
        end
    endfunction

    function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_LFO_MODE:     m_mode  = data[1:0];
            CFG_SPEED:        m_speed = data[6:0];
            CFG_OFFSET_MODE:  m_peak  = data[0];
            CFG_STEP_LENGTH:  m_len   = data[6:0];
            CFG_TRIGGER_MASK: m_trig  = data;
            CFG_ENABLE:       m_en    = data[0];
            default:
            begin
                if (idx >= CFG_ROUTE_BASE && int'(idx - CFG_ROUTE_BASE) < SLOTS)
                    m_route[int'(idx - CFG_ROUTE_BASE)] = data[ROUTE_W-1:0];
            end
        endcase
    endfunction

    // Offset plus wave, less the depth or half of it, clamped to the value range
    function automatic logic [6:0] slot_level(int s);
        int depth;
        int wv;
        int lvl;
        depth = int'(m_route[s][6:0]);
        wv = 0;
        if (m_phase <= WAVE_LEN)
            wv = int'(m_wave[s*SPAN + m_phase]);
        if (!m_peak)
            lvl = int'(m_offs[s]) + wv - depth / 2;
        else
            lvl = int'(m_offs[s]) - depth + wv;
        if (lvl > int'(VAL_MAX))
            lvl = int'(VAL_MAX);
        if (lvl < 0)
            lvl = 0;
        return 7'(lvl);
    endfunction

    function automatic void advance_sequencer(cmd_word_t w);
        int        s;
        int        dest;
        int        len;
        res_word_t r;
        tick_words.delete();
        case (w.command)
            CMD_LOAD:
            begin
                if (int'(w.table_index) <= WAVE_LEN)
                    m_wave[int'(w.slot_select)*SPAN + int'(w.table_index)] = w.table_value;
            end
            CMD_OFFSET:
            begin
                for (s = 0; s < SLOTS; s++)
                    if (m_route[s][ROUTE_W-1:14] == w.dest_select)
                        m_offs[s] = w.offset_value;
            end
            CMD_TICK:
            begin
                if (w.clock_phase == 4'd0 && m_mode != MODE_FREE && m_trig[m_step])
                    m_phase = 0;
                if (m_en)
                begin
                    for (s = 0; s < SLOTS; s++)
                    begin
                        dest = int'(m_route[s][ROUTE_W-1:14]);
                        if (dest != 0 && dest <= LAST_DEST)
                        begin
                            r.target_is_fx = (dest > TRACKS);
                            r.target_index = (dest <= TRACKS) ? 4'(dest - 1)
                                                              : 4'(dest - TRACKS - 1);
                            r.param_number = m_route[s][13:7];
                            r.mod_value    = slot_level(s);
                            r.last         = 1'b0;
                            tick_words.push_back(r);
                        end
                    end
                    if (tick_words.size() > 0)
                    begin
                        r = tick_words.pop_back();
                        r.last = 1'b1;
                        tick_words.push_back(r);
                    end
                end
                if (m_speed == 0)
                    m_phase = (m_phase + 2) & 255;
                else
                begin
                    m_hold = (m_hold + 1) & 127;
                    if (m_hold >= int'(m_speed) - 1)
                    begin
                        m_hold  = 0;
                        m_phase = (m_phase + 1) & 255;
                    end
                end
                if (m_phase > WAVE_LEN)
                    m_phase = (m_mode == MODE_ONESHOT) ? WAVE_LEN : 0;
                if (w.clock_phase == LAST_TICK_PHASE)
                begin
                    len = (m_len == 0) ? 1 : int'(m_len);
                    if (m_step >= len - 1)
                        m_step = 0;
                    else
                        m_step = (m_step + 1) & 63;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, int want_v, int got_v);
        if (want_v != got_v)
        begin
            fails++;
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, name, want_v, got_v);
        end
    endfunction

    // Predict on every accepted command word, check every accepted result word
    always @(posedge clk)
    begin
        res_word_t want;
        if (rst_n)
        begin
            quiet_cycles++;
            if (cmd_valid && cmd_ready)
            begin
                quiet_cycles = 0;
                advance_sequencer(cmd);
                if (cmd_tag >= 0 && plan[cmd_tag].n_typed >= 0)
                begin
                    if (plan[cmd_tag].n_typed >= 1)
                        awaited_words.push_back(plan[cmd_tag].t0);
                    if (plan[cmd_tag].n_typed >= 2)
                        awaited_words.push_back(plan[cmd_tag].t1);
                end
                else
                    foreach (tick_words[i])
                        awaited_words.push_back(tick_words[i]);
            end
            if (res_valid && res_ready)
            begin
                quiet_cycles = 0;
                if (awaited_words.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result word: expected none, actual %h",
                             $time, res);
                end
                else
                begin
                    want = awaited_words.pop_front();
                    check_field("target_is_fx", want.target_is_fx, res.target_is_fx);
                    check_field("target_index", want.target_index, res.target_index);
                    check_field("param_number", want.param_number, res.param_number);
                    check_field("mod_value", want.mod_value, res.mod_value);
                    check_field("last", want.last, res.last);
                end
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Result side back-pressure
    always @(posedge clk)
        res_ready <= steady || ($urandom_range(0, 99) >= 31);

    task automatic send_word(cmd_word_t w, int tag);
        while (!steady && $urandom_range(0, 99) < 31)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd       <= w;
        cmd_tag   <= tag;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
    endtask

    // Hold the sender until every awaited word is back, then let the block settle
    task automatic drain(int extra);
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_wr_en <= 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        apply_reg(idx, data);
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_route();
        int dest;
        int depth;
        int pick;
        dest = ($urandom_range(0, 99) < 85) ? $urandom_range(1, LAST_DEST)
                                            : $urandom_range(0, 31);
        pick = $urandom_range(0, 99);
        depth = (pick < 15) ? 0 : (pick < 30) ? 127 : $urandom_range(0, 127);
        return route_code(dest, $urandom_range(0, 127), depth);
    endfunction

    task automatic randomize_config(int p);
        logic [CFG_DATA_W-1:0] v;
        write_reg(CFG_LFO_MODE, 64'(p % 4));
        case (p)
            0:       v = '0;
            1:       v = 64'd127;
            2:       v = 64'd1;
            default: v = ($urandom_range(0, 99) < 70) ? 64'($urandom_range(0, 6))
                                                      : 64'($urandom_range(0, 127));
        endcase
        write_reg(CFG_SPEED, v);
        write_reg(CFG_OFFSET_MODE, 64'(p % 2));
        case (p)
            1:       v = 64'd1;
            3:       v = '0;
            5:       v = 64'd127;
            7:       v = 64'd64;
            default: v = ($urandom_range(0, 99) < 80) ? 64'($urandom_range(1, 8))
                                                      : 64'($urandom_range(1, 64));
        endcase
        write_reg(CFG_STEP_LENGTH, v);
        case (p)
            0:       v = '0;
            2:       v = '1;
            default: v = {$urandom(), $urandom()};
        endcase
        write_reg(CFG_TRIGGER_MASK, v);
        write_reg(CFG_ENABLE, (p == 6) ? 64'd0 : 64'd1);
        for (int s = 0; s < SLOTS; s++)
            write_reg(CFG_ROUTE_BASE + CFG_INDEX_W'(s), random_route());
    endtask

    initial
    begin
        res_word_t fx_top;
        res_word_t track_floor;
        cmd_word_t w;
        bit        cfg_done;
        int        beat;
        int        made;
        int        k;
        int        pick;

        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        cmd       <= '0;
        cmd_valid <= 1'b0;
        cmd_tag   <= -1;
        steady    <= 1'b0;
        model_reset();

        // Slot 0 on the last effect at full offset, slot 1 on track 0 at zero offset
        fx_top      = res_word_t'{1'b1, 4'd3, 7'd127, VAL_MAX, 1'b0};
        track_floor = res_word_t'{1'b0, 4'd0, 7'd0, 7'd0, 1'b1};

        add_cmd(make_word(CMD_TICK, 4'd0, 0, 0, 0, 0, 0), 0);
        add_cfg(CFG_ENABLE, 64'd1);
        add_cfg(CFG_ROUTE_BASE, route_code(LAST_DEST, 127, 0));
        add_cfg(CFG_ROUTE_BASE + 4'd1, route_code(1, 0, 127));
        add_cmd(make_word(CMD_OFFSET, 0, 0, 0, 0, 5'(LAST_DEST), 7'd127));
        add_cmd(make_word(CMD_OFFSET, 0, 0, 0, 0, 5'd1, 7'd0));
        add_cmd(make_word(CMD_TICK, 4'd0, 0, 0, 0, 0, 0), 2, fx_top, track_floor);
        add_cmd(make_word(CMD_TICK, LAST_TICK_PHASE, 0, 0, 0, 0, 0), 2, fx_top, track_floor);
        add_cmd(make_word(CMD_TICK, 4'd15, 1, '1, '1, '1, '1), 2, fx_top, track_floor);
        // Out-of-range loads drop; the table stays as preloaded
        add_cmd(make_word(CMD_LOAD, 0, 0, 6'd63, 7'd0, 0, 0));
        add_cmd(make_word(CMD_LOAD, 0, 1, 6'(SPAN), 7'd127, 0, 0));
        add_cmd(make_word(CMD_TICK, 4'd1, 0, 0, 0, 0, 0), 2, fx_top, track_floor);
        add_cmd(make_word(CMD_UNUSED, '1, 1, '1, '1, '1, '1));
        add_cmd(make_word(CMD_OFFSET, 0, 0, 0, 0, 5'd0, 7'd55));
        add_cmd(make_word(CMD_OFFSET, 0, 0, 0, 0, 5'd31, 7'd1));
        add_cmd(make_word(CMD_LOAD, 0, 0, 6'd0, 7'd0, 0, 0));
        add_cmd(make_word(CMD_LOAD, 0, 0, 6'(WAVE_LEN), 7'd0, 0, 0));
        add_cmd(make_word(CMD_LOAD, 0, 1, 6'd0, 7'd127, 0, 0));
        add_cmd(make_word(CMD_TICK, 4'd2, 0, 0, 0, 0, 0));
        add_cmd(make_word(CMD_TICK, 4'd3, 0, 0, 0, 0, 0));
        add_cfg(CFG_OFFSET_MODE, 64'd1);
        add_cmd(make_word(CMD_TICK, 4'd4, 0, 0, 0, 0, 0));
        // Destinations past the effects are off
        add_cfg(CFG_ROUTE_BASE, route_code(LAST_DEST + 1, 5, 9));
        add_cfg(CFG_ROUTE_BASE + 4'd1, 64'h7FFFF);
        add_cmd(make_word(CMD_TICK, 4'd5, 0, 0, 0, 0, 0), 0);
        // Offset for destination zero lands on the slot that is off
        add_cfg(CFG_ROUTE_BASE + 4'd1, 64'd0);
        add_cmd(make_word(CMD_OFFSET, 0, 0, 0, 0, 5'd0, 7'd9));
        add_cfg(CFG_ROUTE_BASE + 4'd1, route_code(TRACKS, 64, 0));
        add_cmd(make_word(CMD_TICK, 4'd6, 0, 0, 0, 0, 0));
        add_cfg(CFG_LFO_MODE, 64'd3);
        add_cfg(CFG_TRIGGER_MASK, '1);
        add_cfg(CFG_STEP_LENGTH, 64'd0);
        add_cfg(CFG_SPEED, 64'd1);
        add_cmd(make_word(CMD_TICK, 4'd0, 0, 0, 0, 0, 0));
        add_cmd(make_word(CMD_TICK, LAST_TICK_PHASE, 0, 0, 0, 0, 0));
        add_cmd(make_word(CMD_TICK, 4'd0, 0, 0, 0, 0, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill both wave tables so no tick reads an unwritten sample
        for (int s = 0; s < SLOTS; s++)
            for (int i = 0; i < SPAN; i++)
                send_word(make_word(CMD_LOAD, 0, 1'(s), 6'(i), (s == 0) ? VAL_MAX : 7'd0,
                                    0, 0), -1);

        cfg_done = 1'b0;
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                if (!cfg_done)
                    drain(SETTLE_CYCLES);
                write_reg(plan[i].idx, plan[i].data);
                cfg_done = 1'b1;
            end
            else
            begin
                send_word(plan[i].w, i);
                cfg_done = 1'b0;
            end
        end

        beat = 0;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain(SETTLE_CYCLES);
            steady <= (p == 4 || p == 5);
            randomize_config(p);
            made = 0;
            k    = 0;
            while (made < ITEMS_PER_PHASE)
            begin
                w = cmd_word_t'($urandom());
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    // well-formed run of clock phases 0..11
                    w.command     = CMD_TICK;
                    w.clock_phase = 4'(beat);
                    beat = (beat + 1) % 12;
                    made++;
                end
                else if (pick < 80)
                begin
                    w.command     = CMD_LOAD;
                    w.table_index = 6'($urandom_range(0, WAVE_LEN));
                    made++;
                end
                else if (pick < 88)
                begin
                    w.command = CMD_OFFSET;
                    if (pick < 85)
                        w.dest_select = m_route[$urandom_range(0, SLOTS - 1)][ROUTE_W-1:14];
                    made++;
                end
                else if (pick < 92)
                begin
                    w.command     = CMD_LOAD;
                    w.table_index = 6'($urandom_range(SPAN, 63));
                end
                else if (pick < 96)
                    w.command = CMD_UNUSED;
                else
                begin
                    w.command     = CMD_TICK;
                    w.clock_phase = 4'($urandom_range(0, 15));
                    made++;
                end
                send_word(w, -1);
                k++;
                if ((p == 3 && k == 40) || $urandom_range(0, 299) == 0)
                    drain(0);
            end
        end

        drain(2 * SETTLE_CYCLES);
        if (fails == 0 && awaited_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
